// File: hdl/rri_pkg.sv
// shared types, constants and helpers for the ray/rectangle intersection core
`default_nettype none
package rri_pkg;

	localparam int COORD_W        = 32;
	localparam int ENT_W          = 16;
	localparam int ENT_FRAC       = 8;
	localparam int SIZE_W         = 31;
	localparam int ROW_W          = 64;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 64;
	localparam int COORD_FRAC_DEF = 16;

	localparam int PROD_W   = ENT_W + COORD_W;
	localparam int LOC_W    = 50;
	localparam int REM_W    = LOC_W + 1;
	localparam int Q_W      = 32;
	localparam int QM_W     = Q_W + 1;
	localparam int T_W      = Q_W + 2;
	localparam int MAG_LO_W = LOC_W / 2;
	localparam int MAG_HI_W = LOC_W - MAG_LO_W;
	localparam int WIDE_W   = LOC_W + QM_W;
	localparam int DPROD_W  = COORD_W + QM_W;
	localparam int MS_W     = 64;

	localparam int DIV_BITS   = 4;
	localparam int DIV_STAGES = Q_W / DIV_BITS;

	localparam int XF_LAT  = 2;
	localparam int DIV_LAT = DIV_STAGES + 1;
	localparam int HIT_LAT = 4;
	localparam int LATENCY = XF_LAT + DIV_LAT + HIT_LAT;

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW0   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2   = 3'd4;

	localparam logic [SIZE_W-1:0] SIZE_RST = 31'd65536;
	localparam logic [ROW_W-1:0]  ROW0_RST = 64'h0100_0000_0000_0000;
	localparam logic [ROW_W-1:0]  ROW1_RST = 64'h0000_0100_0000_0000;
	localparam logic [ROW_W-1:0]  ROW2_RST = 64'h0000_0000_0100_0000;

	localparam logic [MS_W-1:0]        P_CAP   = 64'h2000_0000_0000_0000;
	localparam logic signed [MS_W-1:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [MS_W-1:0] S32_MIN = -64'sd2147483648;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [LOC_W-1:0]   loc_t;
	typedef logic [ROW_W-1:0]          row_t;

	typedef struct packed {
		coord_t [2:0] o;
		coord_t [2:0] d;
		coord_t       t_near;
		coord_t       t_far;
		coord_t       t_closest;
	} ray_t;

	typedef struct packed {
		ray_t       ray;
		loc_t [2:0] lo;
		loc_t [2:0] ld;
	} local_ray_t;

	typedef struct packed {
		ray_t            ray;
		loc_t            lo_x;
		loc_t            lo_z;
		loc_t            ld_x;
		loc_t            ld_z;
		logic            zero;
		logic            neg;
		logic [QM_W-1:0] t_mag;
	} div_res_t;

	function automatic logic signed [ENT_W-1:0] row_entry(input row_t row, input int k);
		return row[ROW_W-1-ENT_W*k -: ENT_W];
	endfunction

	function automatic coord_t sat32(input logic signed [MS_W-1:0] v);
		coord_t r;
		if (v > S32_MAX) begin
			r = coord_t'(S32_MAX);
		end else if (v < S32_MIN) begin
			r = coord_t'(S32_MIN);
		end else begin
			r = coord_t'(v);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: hdl/rri_xform.sv
// world-to-local transform of ray origin and direction, two stages
`default_nettype none
module rri_xform #(
	parameter int FRAC = rri_pkg::COORD_FRAC_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  rri_pkg::ray_t           in_ray,
	input  rri_pkg::row_t [2:0]     rows,
	output logic                    out_valid,
	output rri_pkg::local_ray_t     out_data
);
	import rri_pkg::*;

	logic                     valid_s1;
	ray_t                     ray_s1;
	logic signed [PROD_W-1:0] po_s1 [3][3];
	logic signed [PROD_W-1:0] pd_s1 [3][3];
	loc_t                     tr_s1 [3];
	logic                     valid_s2;
	local_ray_t               data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// entry products
	always_ff @(posedge clk) begin
		ray_s1 <= in_ray;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				po_s1[i][j] <= row_entry(rows[i], j) * $signed(in_ray.o[j]);
				pd_s1[i][j] <= row_entry(rows[i], j) * $signed(in_ray.d[j]);
			end
			tr_s1[i] <= LOC_W'(row_entry(rows[i], 3)) <<< FRAC;
		end
	end

	// row sums
	always_ff @(posedge clk) begin
		data_s2.ray <= ray_s1;
		for (int i = 0; i < 3; i++) begin
			data_s2.lo[i] <= LOC_W'(po_s1[i][0]) + LOC_W'(po_s1[i][1])
				+ LOC_W'(po_s1[i][2]) + tr_s1[i];
			data_s2.ld[i] <= LOC_W'(pd_s1[i][0]) + LOC_W'(pd_s1[i][1])
				+ LOC_W'(pd_s1[i][2]);
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule
`default_nettype wire

// File: hdl/rri_div.sv
// pipelined restoring divider for the hit distance |oy| / |dy|
`default_nettype none
module rri_div #(
	parameter int FRAC = rri_pkg::COORD_FRAC_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  rri_pkg::local_ray_t     in_data,
	output logic                    out_valid,
	output rri_pkg::div_res_t       out_data
);
	import rri_pkg::*;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [LOC_W-1:0] den;
		logic [Q_W-1:0]   quot;
		logic [Q_W-1:0]   nbits;
		logic             ovf;
		div_res_t         res;
	} stage_t;

	logic             valid_s [DIV_STAGES+1];
	stage_t           stg_s   [DIV_STAGES+1];
	stage_t           nxt     [DIV_STAGES];
	stage_t           prep;
	logic [LOC_W-1:0] num;
	logic [LOC_W-1:0] den;
	logic [LOC_W-1:0] head;

	always_comb begin
		num  = in_data.lo[1][LOC_W-1] ? LOC_W'(-in_data.lo[1]) : LOC_W'(in_data.lo[1]);
		den  = in_data.ld[1][LOC_W-1] ? LOC_W'(-in_data.ld[1]) : LOC_W'(in_data.ld[1]);
		head = num >> (Q_W - FRAC);
		prep.rem       = REM_W'(head);
		prep.den       = den;
		prep.quot      = '0;
		prep.nbits     = Q_W'(num << FRAC);
		prep.ovf       = head >= den;
		prep.res.ray   = in_data.ray;
		prep.res.lo_x  = in_data.lo[0];
		prep.res.lo_z  = in_data.lo[2];
		prep.res.ld_x  = in_data.ld[0];
		prep.res.ld_z  = in_data.ld[2];
		prep.res.zero  = in_data.ld[1] == '0;
		prep.res.neg   = (in_data.lo[1] != '0)
			&& (in_data.lo[1][LOC_W-1] == in_data.ld[1][LOC_W-1]);
		prep.res.t_mag = '0;
	end

	// quotient bits per stage
	always_comb begin
		stage_t           cur;
		logic [REM_W-1:0] trial;
		for (int k = 0; k < DIV_STAGES; k++) begin
			cur = stg_s[k];
			for (int b = 0; b < DIV_BITS; b++) begin
				trial     = {cur.rem[REM_W-2:0], cur.nbits[Q_W-1]};
				cur.nbits = cur.nbits << 1;
				if (trial >= REM_W'(cur.den)) begin
					cur.rem  = trial - REM_W'(cur.den);
					cur.quot = {cur.quot[Q_W-2:0], 1'b1};
				end else begin
					cur.rem  = trial;
					cur.quot = {cur.quot[Q_W-2:0], 1'b0};
				end
			end
			nxt[k] = cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STAGES; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else begin
			valid_s[0] <= in_valid;
			for (int k = 0; k < DIV_STAGES; k++) begin
				valid_s[k+1] <= valid_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		stg_s[0] <= prep;
		for (int k = 0; k < DIV_STAGES; k++) begin
			stg_s[k+1] <= nxt[k];
		end
	end

	// quotient held at 2^32 on overflow
	always_comb begin
		out_data = stg_s[DIV_STAGES].res;
		out_data.t_mag = stg_s[DIV_STAGES].ovf ? (QM_W'(1) << Q_W)
			: {1'b0, stg_s[DIV_STAGES].quot};
	end

	assign out_valid = valid_s[DIV_STAGES];

endmodule
`default_nettype wire

// File: hdl/rri_hit.sv
// distance bounds, hit point products, rectangle test and output stage
`default_nettype none
module rri_hit #(
	parameter int FRAC = rri_pkg::COORD_FRAC_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  rri_pkg::div_res_t             in_data,
	input  logic [rri_pkg::SIZE_W-1:0]    size_x,
	input  logic [rri_pkg::SIZE_W-1:0]    size_z,
	output logic                          out_valid,
	output logic                          hit,
	output rri_pkg::coord_t               hit_t,
	output rri_pkg::coord_t               hit_x,
	output rri_pkg::coord_t               hit_y,
	output rri_pkg::coord_t               hit_z
);
	import rri_pkg::*;

	logic signed [T_W-1:0] t_c;
	logic signed [T_W-1:0] tn_c;
	logic signed [T_W-1:0] tf_c;
	logic signed [T_W-1:0] tc_c;
	logic                  pass_c;

	logic                  valid_s1;
	logic                  pass_s1;
	logic signed [T_W-1:0] t_s1;
	logic [QM_W-1:0]       tmag_s1;
	div_res_t              res_s1;

	logic [LOC_W-1:0]      ax_c;
	logic [LOC_W-1:0]      az_c;
	logic [COORD_W-1:0]    dm_c [3];

	logic                          valid_s2;
	logic                          pass_s2;
	logic signed [T_W-1:0]         t_s2;
	loc_t                          lo_x_s2;
	loc_t                          lo_z_s2;
	coord_t [2:0]                  o_s2;
	logic [MAG_LO_W+QM_W-1:0]      ppxl_s2;
	logic [MAG_HI_W+QM_W-1:0]      ppxh_s2;
	logic [MAG_LO_W+QM_W-1:0]      ppzl_s2;
	logic [MAG_HI_W+QM_W-1:0]      ppzh_s2;
	logic                          sx_s2;
	logic                          sz_s2;
	logic [DPROD_W-1:0]            ppd_s2 [3];
	logic                          sd_s2  [3];

	logic [WIDE_W-1:0]      wx_c;
	logic [WIDE_W-1:0]      wz_c;
	logic [MS_W-1:0]        mx_c;
	logic [MS_W-1:0]        mz_c;
	logic [MS_W-1:0]        md_c [3];

	logic                   valid_s3;
	logic                   pass_s3;
	logic signed [T_W-1:0]  t_s3;
	loc_t                   lo_x_s3;
	loc_t                   lo_z_s3;
	coord_t [2:0]           o_s3;
	logic signed [MS_W-1:0] msx_s3;
	logic signed [MS_W-1:0] msz_s3;
	logic signed [MS_W-1:0] msd_s3 [3];

	logic signed [MS_W-1:0] px2_c;
	logic signed [MS_W-1:0] pz2_c;
	logic signed [MS_W-1:0] ex_c;
	logic signed [MS_W-1:0] ez_c;
	logic                   hit_c;

	logic   valid_s4;
	logic   hit_s4;
	coord_t hit_t_s4;
	coord_t hit_x_s4;
	coord_t hit_y_s4;
	coord_t hit_z_s4;

	// signed distance and bounds
	always_comb begin
		t_c  = in_data.neg ? (T_W'(0) - T_W'(in_data.t_mag)) : T_W'(in_data.t_mag);
		tn_c = T_W'($signed(in_data.ray.t_near));
		tf_c = T_W'($signed(in_data.ray.t_far));
		tc_c = T_W'($signed(in_data.ray.t_closest));
		pass_c = !in_data.zero && !(t_c > tc_c) && (t_c > tn_c) && !(t_c > tf_c);
	end

	always_ff @(posedge clk) begin
		pass_s1 <= pass_c;
		t_s1    <= t_c;
		tmag_s1 <= in_data.t_mag;
		res_s1  <= in_data;
	end

	// partial products on magnitudes
	always_comb begin
		ax_c = res_s1.ld_x[LOC_W-1] ? LOC_W'(-res_s1.ld_x) : LOC_W'(res_s1.ld_x);
		az_c = res_s1.ld_z[LOC_W-1] ? LOC_W'(-res_s1.ld_z) : LOC_W'(res_s1.ld_z);
		for (int i = 0; i < 3; i++) begin
			dm_c[i] = res_s1.ray.d[i][COORD_W-1] ? COORD_W'(-$signed(res_s1.ray.d[i]))
				: COORD_W'(res_s1.ray.d[i]);
		end
	end

	always_ff @(posedge clk) begin
		pass_s2 <= pass_s1;
		t_s2    <= t_s1;
		lo_x_s2 <= res_s1.lo_x;
		lo_z_s2 <= res_s1.lo_z;
		o_s2    <= res_s1.ray.o;
		ppxl_s2 <= ax_c[MAG_LO_W-1:0] * tmag_s1;
		ppxh_s2 <= ax_c[LOC_W-1:MAG_LO_W] * tmag_s1;
		ppzl_s2 <= az_c[MAG_LO_W-1:0] * tmag_s1;
		ppzh_s2 <= az_c[LOC_W-1:MAG_LO_W] * tmag_s1;
		sx_s2   <= res_s1.ld_x[LOC_W-1] ^ t_s1[T_W-1];
		sz_s2   <= res_s1.ld_z[LOC_W-1] ^ t_s1[T_W-1];
		for (int i = 0; i < 3; i++) begin
			ppd_s2[i] <= dm_c[i] * tmag_s1;
			sd_s2[i]  <= res_s1.ray.d[i][COORD_W-1] ^ t_s1[T_W-1];
		end
	end

	// combine, rescale and clamp
	always_comb begin
		wx_c = (WIDE_W'(ppxh_s2) << MAG_LO_W) + WIDE_W'(ppxl_s2);
		wz_c = (WIDE_W'(ppzh_s2) << MAG_LO_W) + WIDE_W'(ppzl_s2);
		mx_c = ((wx_c >> FRAC) > WIDE_W'(P_CAP)) ? P_CAP : MS_W'(wx_c >> FRAC);
		mz_c = ((wz_c >> FRAC) > WIDE_W'(P_CAP)) ? P_CAP : MS_W'(wz_c >> FRAC);
		for (int i = 0; i < 3; i++) begin
			md_c[i] = MS_W'(ppd_s2[i] >> FRAC);
		end
	end

	always_ff @(posedge clk) begin
		pass_s3 <= pass_s2;
		t_s3    <= t_s2;
		lo_x_s3 <= lo_x_s2;
		lo_z_s3 <= lo_z_s2;
		o_s3    <= o_s2;
		msx_s3  <= sx_s2 ? -$signed(mx_c) : $signed(mx_c);
		msz_s3  <= sz_s2 ? -$signed(mz_c) : $signed(mz_c);
		for (int i = 0; i < 3; i++) begin
			msd_s3[i] <= sd_s2[i] ? -$signed(md_c[i]) : $signed(md_c[i]);
		end
	end

	// rectangle test against the full size at doubled local position
	always_comb begin
		px2_c = (MS_W'(lo_x_s3) + msx_s3) <<< 1;
		pz2_c = (MS_W'(lo_z_s3) + msz_s3) <<< 1;
		ex_c  = $signed(MS_W'(size_x) << ENT_FRAC);
		ez_c  = $signed(MS_W'(size_z) << ENT_FRAC);
		hit_c = pass_s3 && (px2_c <= ex_c) && (px2_c >= -ex_c)
			&& (pz2_c <= ez_c) && (pz2_c >= -ez_c);
	end

	always_ff @(posedge clk) begin
		hit_s4   <= hit_c;
		hit_t_s4 <= hit_c ? sat32(MS_W'(t_s3)) : '0;
		hit_x_s4 <= hit_c ? sat32(MS_W'($signed(o_s3[0])) + msd_s3[0]) : '0;
		hit_y_s4 <= hit_c ? sat32(MS_W'($signed(o_s3[1])) + msd_s3[1]) : '0;
		hit_z_s4 <= hit_c ? sat32(MS_W'($signed(o_s3[2])) + msd_s3[2]) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	assign out_valid = valid_s4;
	assign hit       = valid_s4 && hit_s4;
	assign hit_t     = valid_s4 ? hit_t_s4 : '0;
	assign hit_x     = valid_s4 ? hit_x_s4 : '0;
	assign hit_y     = valid_s4 ? hit_y_s4 : '0;
	assign hit_z     = valid_s4 ? hit_z_s4 : '0;

endmodule
`default_nettype wire

// File: hdl/ray_rectangle_intersect_core.sv
// top level: configuration registers and the transform, divide and hit pipeline
// One ray request is taken on every cycle that start is high; busy never rises, so
// requests may be issued back to back. Each result appears 15 cycles after its
// request, in request order, on done for exactly one cycle, and must be taken then:
// the depth is set by two transform stages, one divider set-up stage, eight divider
// stages of four quotient bits each and four hit stages. Write the configuration
// registers only when no request is in flight; after reset they hold a unit square
// and the identity matrix. On a miss hit and all result fields are zero.
`default_nettype none
module ray_rectangle_intersect_core #(
	parameter int COORD_FRAC_BITS = rri_pkg::COORD_FRAC_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              cfg_we,
	input  logic [rri_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rri_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  rri_pkg::coord_t                   origin_x,
	input  rri_pkg::coord_t                   origin_y,
	input  rri_pkg::coord_t                   origin_z,
	input  rri_pkg::coord_t                   dir_x,
	input  rri_pkg::coord_t                   dir_y,
	input  rri_pkg::coord_t                   dir_z,
	input  rri_pkg::coord_t                   t_near,
	input  rri_pkg::coord_t                   t_far,
	input  rri_pkg::coord_t                   t_closest,
	output logic                              done,
	output logic                              hit,
	output rri_pkg::coord_t                   hit_t,
	output rri_pkg::coord_t                   hit_x,
	output rri_pkg::coord_t                   hit_y,
	output rri_pkg::coord_t                   hit_z
);
	import rri_pkg::*;

	logic [SIZE_W-1:0] size_x_q;
	logic [SIZE_W-1:0] size_z_q;
	row_t [2:0]        rows_q;
	ray_t              in_ray;
	logic              xf_valid;
	local_ray_t        xf_data;
	logic              dv_valid;
	div_res_t          dv_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q  <= SIZE_RST;
			size_z_q  <= SIZE_RST;
			rows_q[0] <= ROW0_RST;
			rows_q[1] <= ROW1_RST;
			rows_q[2] <= ROW2_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIZE_X: size_x_q  <= cfg_data[SIZE_W-1:0];
				REG_SIZE_Z: size_z_q  <= cfg_data[SIZE_W-1:0];
				REG_ROW0:   rows_q[0] <= cfg_data;
				REG_ROW1:   rows_q[1] <= cfg_data;
				REG_ROW2:   rows_q[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign busy = 1'b0;

	always_comb begin
		in_ray.o[0]      = origin_x;
		in_ray.o[1]      = origin_y;
		in_ray.o[2]      = origin_z;
		in_ray.d[0]      = dir_x;
		in_ray.d[1]      = dir_y;
		in_ray.d[2]      = dir_z;
		in_ray.t_near    = t_near;
		in_ray.t_far     = t_far;
		in_ray.t_closest = t_closest;
	end

	rri_xform #(.FRAC(COORD_FRAC_BITS)) u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.in_ray    (in_ray),
		.rows      (rows_q),
		.out_valid (xf_valid),
		.out_data  (xf_data)
	);

	rri_div #(.FRAC(COORD_FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (xf_valid),
		.in_data   (xf_data),
		.out_valid (dv_valid),
		.out_data  (dv_data)
	);

	rri_hit #(.FRAC(COORD_FRAC_BITS)) u_hit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dv_valid),
		.in_data   (dv_data),
		.size_x    (size_x_q),
		.size_z    (size_z_q),
		.out_valid (done),
		.hit       (hit),
		.hit_t     (hit_t),
		.hit_x     (hit_x),
		.hit_y     (hit_y),
		.hit_z     (hit_z)
	);

	// every result traces back to an earlier accepted request
	a_done_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching request");

	a_hit_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> done)
		else $error("hit outside result strobe");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!hit |-> (hit_t == '0 && hit_x == '0 && hit_y == '0 && hit_z == '0))
		else $error("non-zero result fields on miss");

	a_hit_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> (hit_t <= $past(t_closest, LATENCY) && hit_t > $past(t_near, LATENCY)
			&& hit_t <= $past(t_far, LATENCY)))
		else $error("hit distance outside request bounds");

endmodule
`default_nettype wire
